/* rtl/core/particle_collision_response_macros.svh */
// Assertion helpers for the collision response RTL.
`ifndef PARTICLE_COLLISION_RESPONSE_MACROS_SVH
`define PARTICLE_COLLISION_RESPONSE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define PCR_CHK_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcr: same-cycle check failed");

// Next-cycle implication.
`define PCR_CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcr: next-cycle check failed");

`endif

/* rtl/core/pcr_pkg.sv */
`timescale 1ns / 1ps

package pcr_pkg;

	localparam int POS_W = 20;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// register index = paddr[5:3]
	localparam logic [2:0] REG_BOX_CENTER = 3'd0;
	localparam logic [2:0] REG_BOX_HALF = 3'd1;
	localparam logic [2:0] REG_SPH_CENTER = 3'd2;
	localparam logic [2:0] REG_SPH_RADIUS = 3'd3;
	localparam logic [2:0] REG_SKIN = 3'd4;
	localparam logic [2:0] REG_FRICTION = 3'd5;

	localparam logic [59:0] BOX_CENTER_RST = 60'd1097364144128;
	localparam logic [59:0] BOX_HALF_RST = 60'd67553996558102528;
	localparam logic [59:0] SPH_CENTER_RST = 60'd8589934592;
	localparam logic [18:0] SPH_RADIUS_RST = 19'd8192;
	localparam logic [11:0] SKIN_RST = 12'd205;
	localparam logic [12:0] FRICTION_RST = 13'd3686;

	// iterative units: steps per pipeline stage
	localparam int STEPS = 3;
	localparam int SQ_BITS = 21;
	localparam int DV_BITS = 17;
	localparam int SQ_STG = (SQ_BITS + STEPS - 1) / STEPS;
	localparam int DV_STG = (DV_BITS + STEPS - 1) / STEPS;
	localparam int IT_STG = SQ_STG + DV_STG;

	typedef logic signed [POS_W-1:0] pos_t;

	// context carried through the square root and divider stages
	typedef struct packed {
		logic [2:0][POS_W-1:0] p;
		logic [2:0][POS_W-1:0] o;
		logic [2:0][20:0] d;
		logic [2:0][20:0] v;
		logic bh;
		logic hit;
		logic zero;
		logic inward;
		logic [41:0] x;
		logic [42:0] rt;
		logic [20:0] len;
		logic [2:0][37:0] rem;
		logic [2:0][DV_BITS-1:0] q;
		logic [2:0] neg;
	} sp_t;

	// shift right by s, round to nearest, ties away from zero
	function automatic logic signed [47:0] rnd_shr(input logic signed [47:0] a,
		input int unsigned s);
		logic signed [47:0] half;
		half = 48'sd1 <<< (s - 1);
		return (a + half - ((a < 0) ? 48'sd1 : 48'sd0)) >>> s;
	endfunction

	function automatic pos_t sat_pos(input logic signed [47:0] a);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = (48'sd1 <<< (POS_W - 1)) - 48'sd1;
		lo = -(48'sd1 <<< (POS_W - 1));
		if (a > hi)
			return hi[POS_W-1:0];
		else if (a < lo)
			return lo[POS_W-1:0];
		return a[POS_W-1:0];
	endfunction

endpackage

/* rtl/core/pcr_ifs.sv */
`timescale 1ns / 1ps

interface pcr_in_if;
	import pcr_pkg::*;
	logic valid;
	logic ready;
	pos_t cur_x;
	pos_t cur_y;
	pos_t cur_z;
	pos_t old_x;
	pos_t old_y;
	pos_t old_z;
	modport source(output valid, cur_x, cur_y, cur_z, old_x, old_y, old_z, input ready);
	modport sink(input valid, cur_x, cur_y, cur_z, old_x, old_y, old_z, output ready);
endinterface

interface pcr_out_if;
	import pcr_pkg::*;
	logic valid;
	logic ready;
	pos_t new_cur_x;
	pos_t new_cur_y;
	pos_t new_cur_z;
	pos_t new_old_x;
	pos_t new_old_y;
	pos_t new_old_z;
	logic box_hit;
	logic sphere_hit;
	modport source(output valid, new_cur_x, new_cur_y, new_cur_z, new_old_x, new_old_y,
		new_old_z, box_hit, sphere_hit, input ready);
	modport sink(input valid, new_cur_x, new_cur_y, new_cur_z, new_old_x, new_old_y,
		new_old_z, box_hit, sphere_hit, output ready);
endinterface

/* rtl/core/particle_collision_response.sv */
// channel   | dir | carries
// ----------+-----+---------------------------------------------------
// particle  | in  | cur_x/y/z, old_x/y/z (Q8.12), valid/ready
// result    | out | new_cur_x/y/z, new_old_x/y/z, box_hit, sphere_hit
// APB       | in  | 64-bit config writes/reads, register i at 8*i
//
// One item per cycle while no result is held at the output. Depth is set by the
// square root (7 stages) and the normal divider (6 stages), 3 steps each.
// arst_n clears the valid bits and loads the config register defaults.
// The whole pipe holds while a result waits; nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "particle_collision_response_macros.svh"

module particle_collision_response (
	input logic clk,
	input logic arst_n,
	pcr_in_if.sink particle,
	pcr_out_if.source result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pcr_pkg::ADDR_W-1:0] paddr,
	input logic [pcr_pkg::DATA_W-1:0] pwdata,
	output logic [pcr_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import pcr_pkg::*;

	localparam int N_STG = 8 + IT_STG + 6;

	// ---------------- configuration registers ----------------
	logic [59:0] box_center_q, box_half_q, sph_center_q;
	logic [18:0] sph_radius_q;
	logic [11:0] skin_q;
	logic [12:0] friction_q;
	logic [2:0] reg_idx;

	assign reg_idx = paddr[ADDR_W-1:3];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_center_q <= BOX_CENTER_RST;
			box_half_q <= BOX_HALF_RST;
			sph_center_q <= SPH_CENTER_RST;
			sph_radius_q <= SPH_RADIUS_RST;
			skin_q <= SKIN_RST;
			friction_q <= FRICTION_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_BOX_CENTER: box_center_q <= pwdata[59:0];
				REG_BOX_HALF: box_half_q <= pwdata[59:0];
				REG_SPH_CENTER: sph_center_q <= pwdata[59:0];
				REG_SPH_RADIUS: sph_radius_q <= pwdata[18:0];
				REG_SKIN: skin_q <= pwdata[11:0];
				REG_FRICTION: friction_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BOX_CENTER: prdata = {4'd0, box_center_q};
			REG_BOX_HALF: prdata = {4'd0, box_half_q};
			REG_SPH_CENTER: prdata = {4'd0, sph_center_q};
			REG_SPH_RADIUS: prdata = {45'd0, sph_radius_q};
			REG_SKIN: prdata = {52'd0, skin_q};
			REG_FRICTION: prdata = {51'd0, friction_q};
			default: prdata = '0;
		endcase
	end

	// derived geometry; the user must change config only while the pipe is empty; the block leaves this unchecked
	pos_t bc [3];
	pos_t sc [3];
	logic [19:0] bhalf [3];
	logic signed [21:0] lo [3], hi [3], lom [3], him [3];
	logic [19:0] rsk;                  // radius + skin
	logic signed [13:0] frs;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bc[i] = box_center_q[20*i +: 20];
			sc[i] = sph_center_q[20*i +: 20];
			bhalf[i] = box_half_q[20*i +: 20];
			lo[i] = 22'(bc[i]) - $signed({2'b00, bhalf[i]});
			hi[i] = 22'(bc[i]) + $signed({2'b00, bhalf[i]});
			lom[i] = lo[i] - $signed({10'd0, skin_q});
			him[i] = hi[i] + $signed({10'd0, skin_q});
		end
	end

	assign rsk = 20'(sph_radius_q) + 20'(skin_q);
	assign frs = $signed({1'b0, friction_q});

	// ---------------- flow control ----------------
	logic [N_STG-1:0] vld_q;
	logic adv;

	assign adv = !vld_q[N_STG-1] || result.ready;
	assign particle.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[N_STG-2:0], particle.valid};
	end

	// ---------------- box: s1 bounds and depths ----------------
	pos_t pin [3], oin [3];
	assign pin[0] = particle.cur_x;
	assign pin[1] = particle.cur_y;
	assign pin[2] = particle.cur_z;
	assign oin[0] = particle.old_x;
	assign oin[1] = particle.old_y;
	assign oin[2] = particle.old_z;

	pos_t p_s1 [3], o_s1 [3];
	logic [2:0] ins_s1;
	logic signed [22:0] dlo_s1 [3], dhi_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= pin[i];
				o_s1[i] <= oin[i];
				ins_s1[i] <= (22'(pin[i]) >= lom[i]) && (22'(pin[i]) <= him[i]);
				dlo_s1[i] <= 23'(pin[i]) - 23'(lo[i]);
				dhi_s1[i] <= 23'(hi[i]) - 23'(pin[i]);
			end
		end
	end

	// s2: nearer face per axis, tie to the minus face
	pos_t p_s2 [3], o_s2 [3];
	logic signed [22:0] fd_s2 [3];
	logic [2:0] fp_s2;
	logic bh_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= p_s1[i];
				o_s2[i] <= o_s1[i];
				fp_s2[i] <= dhi_s1[i] < dlo_s1[i];
				fd_s2[i] <= (dhi_s1[i] < dlo_s1[i]) ? dhi_s1[i] : dlo_s1[i];
			end
			bh_s2 <= &ins_s1;
		end
	end

	// s3: pick the axis (earlier axis wins ties), push out, new velocity
	logic [1:0] ax;
	logic signed [21:0] pn [3];
	logic signed [22:0] vb [3];
	logic inw;

	always_comb begin
		if (fd_s2[0] <= fd_s2[1] && fd_s2[0] <= fd_s2[2])
			ax = 2'd0;
		else if (fd_s2[1] <= fd_s2[2])
			ax = 2'd1;
		else
			ax = 2'd2;
		for (int i = 0; i < 3; i++) begin
			if (bh_s2 && ax == 2'(i))
				pn[i] = fp_s2[i] ? him[i] : lom[i];
			else
				pn[i] = 22'(p_s2[i]);
			vb[i] = 23'(pn[i]) - 23'(o_s2[i]);
		end
		inw = bh_s2 && (fp_s2[ax] ? (vb[ax] < 0) : (vb[ax] > 0));
	end

	logic signed [21:0] pn_s3 [3], pn_s4 [3];
	pos_t o_s3 [3], o_s4 [3];
	logic signed [22:0] v_s3 [3];
	logic [1:0] a_s3, a_s4;
	logic inw_s3, inw_s4, bh_s3, bh_s4;
	logic signed [36:0] fv_s4 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			pn_s3 <= pn;
			o_s3 <= o_s2;
			v_s3 <= vb;
			a_s3 <= ax;
			inw_s3 <= inw;
			bh_s3 <= bh_s2;
		end
	end

	// s4: friction scaling
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				fv_s4[i] <= frs * v_s3[i];
			pn_s4 <= pn_s3;
			o_s4 <= o_s3;
			a_s4 <= a_s3;
			inw_s4 <= inw_s3;
			bh_s4 <= bh_s3;
		end
	end

	// s5: rebuilt previous position, saturate
	pos_t p_s5 [3], o_s5 [3];
	logic bh_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p_s5[i] <= sat_pos(48'(pn_s4[i]));
				if (!inw_s4)
					o_s5[i] <= o_s4[i];
				else if (a_s4 == 2'(i))
					o_s5[i] <= sat_pos(48'(pn_s4[i]));
				else
					o_s5[i] <= sat_pos(48'(pn_s4[i]) - rnd_shr(48'(fv_s4[i]), 12));
			end
			bh_s5 <= bh_s4;
		end
	end

	// ---------------- sphere: s6 offsets ----------------
	pos_t p_s6 [3], o_s6 [3], p_s7 [3], o_s7 [3];
	logic signed [20:0] d_s6 [3], v_s6 [3], d_s7 [3], v_s7 [3];
	logic signed [41:0] dd_s7 [3], vd_s7 [3];
	logic [39:0] rr_s7;
	logic bh_s6, bh_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s6[i] <= 21'(p_s5[i]) - 21'(sc[i]);
				v_s6[i] <= 21'(p_s5[i]) - 21'(o_s5[i]);
			end
			p_s6 <= p_s5;
			o_s6 <= o_s5;
			bh_s6 <= bh_s5;
		end
	end

	// s7: squares and dot terms
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dd_s7[i] <= d_s6[i] * d_s6[i];
				vd_s7[i] <= v_s6[i] * d_s6[i];
			end
			rr_s7 <= rsk * rsk;
			p_s7 <= p_s6;
			o_s7 <= o_s6;
			d_s7 <= d_s6;
			v_s7 <= v_s6;
			bh_s7 <= bh_s6;
		end
	end

	// s8: |d|^2, v.d, contact test; it_s[0] is the s8 register
	sp_t it_s [0:IT_STG];
	sp_t it_in;
	logic [41:0] d2;
	logic signed [43:0] dvd;

	always_comb begin
		d2 = dd_s7[0][41:0] + dd_s7[1][41:0] + dd_s7[2][41:0];
		dvd = 44'(vd_s7[0]) + 44'(vd_s7[1]) + 44'(vd_s7[2]);
		it_in = '0;
		for (int i = 0; i < 3; i++) begin
			it_in.p[i] = p_s7[i];
			it_in.o[i] = o_s7[i];
			it_in.d[i] = d_s7[i];
			it_in.v[i] = v_s7[i];
		end
		it_in.bh = bh_s7;
		it_in.hit = d2 <= {2'b00, rr_s7};
		it_in.zero = d2 == '0;
		it_in.inward = dvd < 0;
		it_in.x = d2;
		it_in.rt = '0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			it_s[0] <= it_in;
	end

	// square root digit recurrence, then the restoring divider for the
	// normal, STEPS iterations per stage
	for (genvar g = 1; g <= IT_STG; g++) begin : g_it
		sp_t t;
		always_comb begin
			logic [42:0] bv;
			logic [37:0] dsh;
			logic [20:0] mag;
			int k;
			int kb;
			t = it_s[g-1];
			if (g <= SQ_STG) begin
				for (int j = 0; j < STEPS; j++) begin
					k = (g - 1) * STEPS + j;
					if (k < SQ_BITS) begin
						bv = 43'd1 << (2 * (SQ_BITS - 1 - k));
						if ({1'b0, t.x} >= t.rt + bv) begin
							t.x = t.x - 42'(t.rt + bv);
							t.rt = (t.rt >> 1) + bv;
						end else begin
							t.rt = t.rt >> 1;
						end
					end
				end
			end else begin
				if (g == SQ_STG + 1) begin
					t.len = t.rt[20:0];
					t.q = '0;
					for (int i = 0; i < 3; i++) begin
						t.neg[i] = t.d[i][20];
						mag = t.d[i][20] ? 21'(-$signed(t.d[i])) : t.d[i];
						t.rem[i] = {1'b0, mag, 16'd0} + 38'(t.len >> 1);
					end
				end
				for (int j = 0; j < STEPS; j++) begin
					k = (g - 1 - SQ_STG) * STEPS + j;
					if (k < DV_BITS) begin
						kb = DV_BITS - 1 - k;
						dsh = 38'(t.len) << kb;
						for (int i = 0; i < 3; i++) begin
							if (t.rem[i] >= dsh) begin
								t.rem[i] = t.rem[i] - dsh;
								t.q[i][kb] = 1'b1;
							end
						end
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				it_s[g] <= t;
		end
	end

	// ---------------- sphere response ----------------
	sp_t tt;
	assign tt = it_s[IT_STG];

	// s22: signed normal, n*R and v.n terms
	logic signed [17:0] n_s22 [3], n_s23 [3];
	logic signed [38:0] mn_s22 [3], vnp_s22 [3];
	logic signed [20:0] v_s22 [3], v_s23 [3], v_s24 [3];
	pos_t p_s22 [3], o_s22 [3], p_s23 [3], o_s23 [3], p_s24 [3], o_s24 [3];
	pos_t p_s25 [3], o_s25 [3], p_s26 [3], o_s26 [3];
	logic [3:0] fl_s22, fl_s23, fl_s24, fl_s25, fl_s26;  // bh, hit, zero, inward
	logic signed [17:0] nq [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			nq[i] = tt.neg[i] ? -$signed({1'b0, tt.q[i]}) : $signed({1'b0, tt.q[i]});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				n_s22[i] <= nq[i];
				mn_s22[i] <= nq[i] * $signed({1'b0, rsk});
				vnp_s22[i] <= $signed(tt.v[i]) * nq[i];
				v_s22[i] <= tt.v[i];
				p_s22[i] <= tt.p[i];
				o_s22[i] <= tt.o[i];
			end
			fl_s22 <= {tt.bh, tt.hit, tt.zero, tt.inward};
		end
	end

	// s23: pushed position and normal speed
	logic signed [21:0] pc_s23 [3], pc_s24 [3], pc_s25 [3], pc_s26 [3];
	logic signed [22:0] vn_s23;
	logic signed [40:0] vsum;
	logic signed [47:0] vn_r;

	always_comb begin
		vsum = 41'(vnp_s22[0]) + 41'(vnp_s22[1]) + 41'(vnp_s22[2]);
		vn_r = rnd_shr(48'(vsum), 16);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				pc_s23[i] <= 22'(sc[i]) + 22'(rnd_shr(48'(mn_s22[i]), 16));
			vn_s23 <= vn_r[22:0];
			n_s23 <= n_s22;
			v_s23 <= v_s22;
			p_s23 <= p_s22;
			o_s23 <= o_s22;
			fl_s23 <= fl_s22;
		end
	end

	// s24: normal component
	logic signed [40:0] nv_s24 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				nv_s24[i] <= n_s23[i] * vn_s23;
			v_s24 <= v_s23;
			pc_s24 <= pc_s23;
			p_s24 <= p_s23;
			o_s24 <= o_s23;
			fl_s24 <= fl_s23;
		end
	end

	// s25: tangential velocity
	logic signed [23:0] vt_s25 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				vt_s25[i] <= 24'(v_s24[i]) - 24'(rnd_shr(48'(nv_s24[i]), 16));
			pc_s25 <= pc_s24;
			p_s25 <= p_s24;
			o_s25 <= o_s24;
			fl_s25 <= fl_s24;
		end
	end

	// s26: friction on the tangential part
	logic signed [37:0] fv_s26 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				fv_s26[i] <= frs * vt_s25[i];
			pc_s26 <= pc_s25;
			p_s26 <= p_s25;
			o_s26 <= o_s25;
			fl_s26 <= fl_s25;
		end
	end

	// s27: select and saturate; this is the output register
	pos_t p_s27 [3], o_s27 [3];
	logic bh_s27, sh_s27, zero_s27;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (!fl_s26[2]) begin
					p_s27[i] <= p_s26[i];
					o_s27[i] <= o_s26[i];
				end else if (fl_s26[1]) begin
					// cur exactly at the centre: no normal, old kept
					p_s27[i] <= sc[i];
					o_s27[i] <= o_s26[i];
				end else begin
					p_s27[i] <= sat_pos(48'(pc_s26[i]));
					if (fl_s26[0])
						o_s27[i] <= sat_pos(48'(pc_s26[i]) - rnd_shr(48'(fv_s26[i]), 12));
					else
						o_s27[i] <= o_s26[i];
				end
			end
			bh_s27 <= fl_s26[3];
			sh_s27 <= fl_s26[2];
			zero_s27 <= fl_s26[1];
		end
	end

	assign result.valid = vld_q[N_STG-1];
	assign result.new_cur_x = p_s27[0];
	assign result.new_cur_y = p_s27[1];
	assign result.new_cur_z = p_s27[2];
	assign result.new_old_x = o_s27[0];
	assign result.new_old_y = o_s27[1];
	assign result.new_old_z = o_s27[2];
	assign result.box_hit = bh_s27;
	assign result.sphere_hit = sh_s27;

	// ---------------- checks ----------------
	logic at_center;
	assign at_center = p_s27[0] == sc[0] && p_s27[1] == sc[1] && p_s27[2] == sc[2];

	`PCR_CHK_NOW(a_blocked_result_holds_input, result.valid && !result.ready, !particle.ready)
	`PCR_CHK_NEXT(a_accept_enters_pipe, particle.valid && particle.ready, vld_q[0])
	`PCR_CHK_NOW(a_zero_offset_at_center, result.valid && sh_s27 && zero_s27, at_center)

endmodule

/* tb/sv/collision_checker.sv */
`timescale 1ns / 1ps

module collision_checker (
	input logic clk,
	input logic arst_n,
	pcr_in_if particle,
	pcr_out_if result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pcr_pkg::ADDR_W-1:0] paddr,
	input logic [pcr_pkg::DATA_W-1:0] pwdata,
	input logic pready,
	output int errors,
	output int pending
);
	import pcr_pkg::*;

	typedef struct {
		pos_t cx, cy, cz, ox, oy, oz;
		logic bh, sh;
	} contact_t;

	logic [59:0] box_c, box_h, sph_c;
	logic [18:0] radius;
	logic [11:0] skin_w;
	logic [12:0] fric;
	contact_t corrected_q[$];

	initial begin
		errors = 0;
		pending = 0;
	end

	// shadow of the register file, taken from the APB bus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_c <= BOX_CENTER_RST;
			box_h <= BOX_HALF_RST;
			sph_c <= SPH_CENTER_RST;
			radius <= SPH_RADIUS_RST;
			skin_w <= SKIN_RST;
			fric <= FRICTION_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[5:3])
				REG_BOX_CENTER: box_c <= pwdata[59:0];
				REG_BOX_HALF: box_h <= pwdata[59:0];
				REG_SPH_CENTER: sph_c <= pwdata[59:0];
				REG_SPH_RADIUS: radius <= pwdata[18:0];
				REG_SKIN: skin_w <= pwdata[11:0];
				REG_FRICTION: fric <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	function automatic longint round_shift(longint a, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (a >= 0)
			return (a + half) >>> s;
		return -((-a + half) >>> s);
	endfunction

	function automatic longint round_div(longint a, longint b);
		if (a >= 0)
			return (a + b / 2) / b;
		return -((-a + b / 2) / b);
	endfunction

	function automatic longint int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint sfield(logic [59:0] w, int k);
		logic [19:0] f;
		f = w[20*k +: 20];
		return longint'(signed'(f));
	endfunction

	function automatic longint clamp20(longint a);
		if (a > 524287)
			return 524287;
		if (a < -524288)
			return -524288;
		return a;
	endfunction

	function automatic contact_t resolve(pos_t cx, pos_t cy, pos_t cz,
		pos_t ox, pos_t oy, pos_t oz);
		longint p[3], o[3], lo[3], hi[3], dep[6], d[3], v[3], n[3], sc[3];
		longint skin, fr, r, d2, dvd, len, vn, vt, h;
		int best, a;
		contact_t res;
		skin = skin_w;
		fr = fric;
		p[0] = cx; p[1] = cy; p[2] = cz;
		o[0] = ox; o[1] = oy; o[2] = oz;
		res.bh = 1;
		for (int i = 0; i < 3; i++) begin
			h = longint'(box_h[20*i +: 20]);
			lo[i] = sfield(box_c, i) - h;
			hi[i] = sfield(box_c, i) + h;
			if (p[i] < lo[i] - skin || p[i] > hi[i] + skin)
				res.bh = 0;
		end
		if (res.bh) begin
			for (int i = 0; i < 3; i++) begin
				dep[2*i] = p[i] - lo[i];
				dep[2*i+1] = hi[i] - p[i];
			end
			best = 0;
			for (int i = 1; i < 6; i++)
				if (dep[i] < dep[best])
					best = i;
			a = best >> 1;
			if (best & 1)
				p[a] = p[a] + dep[best] + skin;
			else
				p[a] = p[a] - dep[best] - skin;
			for (int i = 0; i < 3; i++)
				v[i] = p[i] - o[i];
			if ((best & 1) ? (v[a] < 0) : (v[a] > 0))
				for (int i = 0; i < 3; i++)
					o[i] = (i == a) ? p[a] : p[i] - round_shift(fr * v[i], 12);
			for (int i = 0; i < 3; i++) begin
				p[i] = clamp20(p[i]);
				o[i] = clamp20(o[i]);
			end
		end
		// sphere works on the box stage output
		r = longint'(radius) + skin;
		d2 = 0;
		dvd = 0;
		for (int i = 0; i < 3; i++) begin
			sc[i] = sfield(sph_c, i);
			d[i] = p[i] - sc[i];
			v[i] = p[i] - o[i];
			d2 += d[i] * d[i];
			dvd += v[i] * d[i];
		end
		res.sh = (d2 <= r * r);
		if (res.sh) begin
			if (d2 == 0) begin
				for (int i = 0; i < 3; i++)
					p[i] = sc[i];
			end else begin
				len = int_sqrt(d2);
				for (int i = 0; i < 3; i++) begin
					n[i] = round_div(d[i] * 65536, len);
					p[i] = sc[i] + round_shift(n[i] * r, 16);
				end
				if (dvd < 0) begin
					vn = round_shift(v[0] * n[0] + v[1] * n[1] + v[2] * n[2], 16);
					for (int i = 0; i < 3; i++) begin
						vt = v[i] - round_shift(n[i] * vn, 16);
						o[i] = p[i] - round_shift(fr * vt, 12);
					end
				end
			end
			for (int i = 0; i < 3; i++) begin
				p[i] = clamp20(p[i]);
				o[i] = clamp20(o[i]);
			end
		end
		res.cx = p[0][19:0]; res.cy = p[1][19:0]; res.cz = p[2][19:0];
		res.ox = o[0][19:0]; res.oy = o[1][19:0]; res.oz = o[2][19:0];
		return res;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		contact_t want;
		if (arst_n) begin
			if (particle.valid && particle.ready)
				corrected_q.push_back(resolve(particle.cur_x, particle.cur_y,
					particle.cur_z, particle.old_x, particle.old_y, particle.old_z));
			if (result.valid && result.ready) begin
				if (corrected_q.size() == 0)
					report("unexpected item", 1, 0);
				else begin
					want = corrected_q.pop_front();
					if (result.new_cur_x !== want.cx) report("new_cur_x", result.new_cur_x, want.cx);
					if (result.new_cur_y !== want.cy) report("new_cur_y", result.new_cur_y, want.cy);
					if (result.new_cur_z !== want.cz) report("new_cur_z", result.new_cur_z, want.cz);
					if (result.new_old_x !== want.ox) report("new_old_x", result.new_old_x, want.ox);
					if (result.new_old_y !== want.oy) report("new_old_y", result.new_old_y, want.oy);
					if (result.new_old_z !== want.oz) report("new_old_z", result.new_old_z, want.oz);
					if (result.box_hit !== want.bh) report("box_hit", result.box_hit, want.bh);
					if (result.sphere_hit !== want.sh)
						report("sphere_hit", result.sphere_hit, want.sh);
				end
			end
			pending = corrected_q.size();
		end
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import pcr_pkg::*;

	localparam int LIMIT = 400000;   // cycles
	localparam int HOLD = 400;       // long receiver hold-off, fills the 27-deep pipe
	localparam int DRAIN = 60;       // settle time after every result is back

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic pready;
	int errors, pending;
	int cycles;

	int send_idle, recv_idle;        // percent of cycles each side idles
	int stall_token, stall_seen, stall_left;
	logic in_fire;

	// local copy of the register settings, used to aim particles at the shapes
	logic [59:0] box_c, box_h, sph_c;
	logic [18:0] radius;
	logic [11:0] skin_w;

	pcr_in_if particle ();
	pcr_out_if result ();

	particle_collision_response dut (
		.clk(clk), .arst_n(arst_n), .particle(particle), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	collision_checker chk (
		.clk(clk), .arst_n(arst_n), .particle(particle), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		cycles = 0;
		forever begin
			#10 clk = 1;
			cycles++;
			#10 clk = 0;
		end
	end

	// watchdog
	initial begin
		while (cycles < LIMIT)
			@(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// handshake seen at the edge, read by the driver at the next falling edge
	always @(posedge clk)
		in_fire <= particle.valid && particle.ready;

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_seen != stall_token) begin
			stall_seen <= stall_token;
			stall_left <= HOLD;
			result.ready <= 1'b0;
		end else
			result.ready <= ($urandom_range(99) >= recv_idle);
	end

	function automatic longint sfield(logic [59:0] w, int k);
		logic [19:0] f;
		f = w[20*k +: 20];
		return longint'(signed'(f));
	endfunction

	function automatic pos_t clip(longint a);
		if (a > 524287)
			return 20'sh7FFFF;
		if (a < -524288)
			return 20'sh80000;
		return a[19:0];
	endfunction

	function automatic longint jitter(int span);
		return longint'($urandom_range(2 * span)) - span;
	endfunction

	function automatic logic [59:0] pack3(longint x, longint y, longint z);
		return {clip(z), clip(y), clip(x)};
	endfunction

	// drive one particle and hold it until it is taken
	task automatic send(longint cx, longint cy, longint cz, longint ox, longint oy,
		longint oz);
		while ($urandom_range(99) < send_idle) begin
			particle.valid = 1'b0;
			@(negedge clk);
		end
		particle.cur_x = clip(cx); particle.cur_y = clip(cy); particle.cur_z = clip(cz);
		particle.old_x = clip(ox); particle.old_y = clip(oy); particle.old_z = clip(oz);
		particle.valid = 1'b1;
		do
			@(negedge clk);
		while (!in_fire);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [63:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic drain();
		particle.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// one register setting per phase; phase 0 keeps the reset values
	task automatic configure(int ph);
		logic [12:0] friction;
		case (ph)
			2: begin   // half sizes, radius, skin and friction at their top
				box_c = pack3(jitter(8192), jitter(8192), jitter(8192));
				box_h = {3{20'hFFFFF}};
				sph_c = pack3(jitter(8192), jitter(8192), jitter(8192));
				radius = 19'h7FFFF;
				skin_w = 12'hFFF;
				friction = 13'h1FFF;
			end
			3: begin   // everything at zero
				box_c = '0;
				box_h = '0;
				sph_c = '0;
				radius = '0;
				skin_w = '0;
				friction = '0;
			end
			6: begin   // centers pinned at the coordinate limits
				box_c = pack3(524287, -524288, 524287);
				box_h = pack3($urandom_range(16384), $urandom_range(16384), $urandom_range(16384));
				sph_c = pack3(-524288, 524287, -524288);
				radius = 19'($urandom_range(20000));
				skin_w = 12'($urandom_range(4095));
				friction = 13'($urandom_range(8191));
			end
			default: begin
				box_c = pack3(jitter(32768), jitter(32768), jitter(32768));
				box_h = pack3($urandom_range(16384), $urandom_range(16384), $urandom_range(16384));
				sph_c = pack3(jitter(32768), jitter(32768), jitter(32768));
				radius = 19'($urandom_range(16384));
				skin_w = 12'($urandom_range(4095));
				friction = (ph == 4) ? 13'd4096 : 13'($urandom_range(8191));
			end
		endcase
		apb_write(REG_BOX_CENTER, {4'b0, box_c});
		apb_write(REG_BOX_HALF, {4'b0, box_h});
		apb_write(REG_SPH_CENTER, {4'b0, sph_c});
		apb_write(REG_SPH_RADIUS, {45'b0, radius});
		apb_write(REG_SKIN, {52'b0, skin_w});
		apb_write(REG_FRICTION, {51'b0, friction});
	endtask

	// random particle, mostly aimed at the box faces or the sphere shell
	task automatic send_random();
		longint c[3], o[3], h, ctr, reach;
		int kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 3; i++) begin
			if (kind <= 3) begin
				ctr = sfield(box_c, i);
				h = longint'(box_h[20*i +: 20]);
				if ($urandom_range(1))
					c[i] = ctr + ($urandom_range(1) ? h : -h) + jitter(skin_w + 600);
				else
					c[i] = ctr + jitter(int'(h) + skin_w + 1);
			end else if (kind <= 6) begin
				reach = longint'(radius) + skin_w + 256;
				c[i] = sfield(sph_c, i) + jitter(int'(reach > 600000 ? 600000 : reach));
			end else
				c[i] = longint'(signed'(20'($urandom())));
		end
		// exact hit on the sphere centre now and then
		if (kind >= 4 && kind <= 6 && $urandom_range(19) == 0)
			for (int i = 0; i < 3; i++)
				c[i] = sfield(sph_c, i);
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(9) < 7)
				o[i] = c[i] + jitter(1500);
			else
				o[i] = longint'(signed'(20'($urandom())));
		end
		send(c[0], c[1], c[2], o[0], o[1], o[2]);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		particle.valid = 1'b0;
		particle.cur_x = '0; particle.cur_y = '0; particle.cur_z = '0;
		particle.old_x = '0; particle.old_y = '0; particle.old_z = '0;
		result.ready = 1'b0;
		stall_token = 0;
		stall_seen = 0;
		stall_left = 0;
		send_idle = 11;
		recv_idle = 47;
		box_c = BOX_CENTER_RST;
		box_h = BOX_HALF_RST;
		sph_c = SPH_CENTER_RST;
		radius = SPH_RADIUS_RST;
		skin_w = SKIN_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, then the special cases under the reset setting
		send(524287, 524287, 524287, 524287, 524287, 524287);
		send(-524288, -524288, -524288, -524288, -524288, -524288);
		send(524287, -524288, 524287, -524288, 524287, -524288);
		send(-524288, 524287, -524288, 524287, -524288, 524287);
		// dead centre of the sphere: normal is zero, old stays
		send(0, 8192, 0, 300, 9000, -100);
		send(0, 8192, 0, 0, 8192, 0);
		// box centre: thin y extent wins, -y and +y tie, the minus face takes it
		send(0, -2048, 0, 0, -3000, 0);
		send(0, -2048, 0, 0, 1000, 0);
		// falling onto the top face, then rising off it
		send(4096, 41, 4096, 4000, 819, 4200);
		send(4096, 41, 4096, 4096, -400, 4096);
		// exactly on the grown -x face and just past it
		send(-61440 - 205, -2048, 0, -61000, -2048, 0);
		send(-61440 - 206, -2048, 0, -61000, -2048, 0);
		// inside the sphere shell, moving in and moving out
		send(0, 14336, 0, 200, 16384, 100);
		send(0, 14336, 0, 0, 12000, 0);
		send(3000, 8192 + 2000, -1000, 4000, 13000, -1500);
		// above the box and outside the sphere at x and z zero: no hit, passes unchanged
		send(0, 41000, 0, 0, 40000, 0);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 3) begin
				send_idle = 11;
				recv_idle = 47;
			end else if (ph < 6) begin
				send_idle = 47;
				recv_idle = 11;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			// sender pauses here until every result is back
			drain();
			if (ph != 0)
				configure(ph);
			if (ph == 2 || ph == 6)
				stall_token++;   // long hold-off while the sender keeps offering
			repeat (100) send_random();
		end

		drain();
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
